FILE: rtl/core/zmssd_pkg.sv
// Shared types and constants for the zero-mean SSD patch matcher.
// No dependencies; every other file refers to it by scoped names.
package zmssd_pkg;

  localparam int unsigned ACT_W   = 2;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned SCORE_W = 22;

  localparam logic [SCORE_W-1:0] SCORE_MAX     = 22'h3F_FFFF;
  // 64 pixels times a per-pixel limit of 500
  localparam logic [SCORE_W-1:0] MAX_SCORE_RST = 22'd32000;

  typedef enum logic [ACT_W-1:0] {
    ACT_TEMPLATE  = 2'd0,
    ACT_CAND      = 2'd1,
    ACT_OFF_IMAGE = 2'd2
  } action_t;

  // Candidate bookkeeping that rides along with the sums down the pipeline
  typedef struct packed {
    logic [COORD_W-1:0] cand_x;
    logic [COORD_W-1:0] cand_y;
    logic               last_cand;
    logic               off_image;
  } cand_tag_t;

endpackage

FILE: rtl/core/zmssd_stream_if.sv
// Valid/ready channel interfaces for the patch matcher's input and result items.
// Depends on zmssd_pkg for field widths.
interface zmssd_in_if;
  logic                            valid;
  logic                            ready;
  logic [zmssd_pkg::ACT_W-1:0]     action;
  logic [zmssd_pkg::PIX_W-1:0]     pixel;
  logic [zmssd_pkg::COORD_W-1:0]   cand_x;
  logic [zmssd_pkg::COORD_W-1:0]   cand_y;
  logic                            last_candidate;

  modport source (output valid, action, pixel, cand_x, cand_y, last_candidate, input ready);
  modport sink   (input valid, action, pixel, cand_x, cand_y, last_candidate, output ready);
endinterface

interface zmssd_out_if;
  logic                            valid;
  logic                            ready;
  logic [zmssd_pkg::SCORE_W-1:0]   score;
  logic                            search_done;
  logic                            found;
  logic [zmssd_pkg::COORD_W-1:0]   best_x;
  logic [zmssd_pkg::COORD_W-1:0]   best_y;

  modport source (output valid, score, search_done, found, best_x, best_y, input ready);
  modport sink   (input valid, score, search_done, found, best_x, best_y, output ready);
endinterface

FILE: rtl/core/zmssd_patch_best_match.sv
// Zero-mean SSD template matcher with best-candidate search. Load a template of
// PATCH_SIZE x PATCH_SIZE pixels (action 0, row-major), then stream candidate
// patches (action 1) tagged with their corner, or flag a candidate off the
// image (action 2, scored max_score + 1). The block takes one item every clock
// cycle unless out_ch.ready stalls it: the template store has one write and one
// registered read port, and every later step is a single stage of the pipeline.
// Once the item that finishes its candidate is accepted, its result passes the
// input register, snapshot, energy/square, divide by pixel count, clamp, then
// the output register that also updates the running best. The closing result of a
// search reports found and the best corner; best_x and best_y are zero unless
// found. Write max_score only while the block is idle; a write restarts the search.
module zmssd_patch_best_match #(
  parameter int unsigned PATCH_SIZE = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  zmssd_in_if.sink                        in_ch,
  zmssd_out_if.source                     out_ch,
  input  logic                            cfg_wr_en,
  input  logic [zmssd_pkg::SCORE_W-1:0]   cfg_wr_data
);

  localparam int unsigned NPIX  = PATCH_SIZE * PATCH_SIZE;
  localparam int unsigned SUM_W = $clog2(NPIX * 255 + 1);
  localparam int unsigned SQ_W  = $clog2(NPIX * 65025 + 1);

  zmssd_pkg::cand_tag_t          in_tag;

  logic                          snap_valid, snap_ready;
  logic [SUM_W-1:0]              snap_isum, snap_tsum;
  logic [SQ_W-1:0]               snap_isq, snap_cross, snap_tsq;
  zmssd_pkg::cand_tag_t          snap_tag;

  logic                          res_valid, res_ready;
  logic [zmssd_pkg::SCORE_W-1:0] res_score;
  zmssd_pkg::cand_tag_t          res_tag;

  assign in_tag = '{cand_x:    in_ch.cand_x,
                    cand_y:    in_ch.cand_y,
                    last_cand: in_ch.last_candidate,
                    off_image: 1'b0};

  zmssd_accum #(
    .PATCH_SIZE (PATCH_SIZE)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_action  (in_ch.action),
    .in_pixel   (in_ch.pixel),
    .in_tag     (in_tag),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap_isum  (snap_isum),
    .snap_isq   (snap_isq),
    .snap_cross (snap_cross),
    .snap_tsum  (snap_tsum),
    .snap_tsq   (snap_tsq),
    .snap_tag   (snap_tag)
  );

  zmssd_score #(
    .PATCH_SIZE (PATCH_SIZE)
  ) u_score (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap_isum  (snap_isum),
    .snap_isq   (snap_isq),
    .snap_cross (snap_cross),
    .snap_tsum  (snap_tsum),
    .snap_tsq   (snap_tsq),
    .snap_tag   (snap_tag),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_score  (res_score),
    .res_tag    (res_tag)
  );

  zmssd_best u_best (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res_score       (res_score),
    .res_tag         (res_tag),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_score       (out_ch.score),
    .out_search_done (out_ch.search_done),
    .out_found       (out_ch.found),
    .out_best_x      (out_ch.best_x),
    .out_best_y      (out_ch.best_y)
  );

endmodule

FILE: rtl/core/zmssd_accum.sv
// Input stage: pixel counter, template store, template and image accumulators,
// and the snapshot register handed to the score pipeline. Depends on zmssd_pkg.
module zmssd_accum #(
  parameter int unsigned PATCH_SIZE = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [zmssd_pkg::ACT_W-1:0]     in_action,
  input  logic [zmssd_pkg::PIX_W-1:0]     in_pixel,
  input  zmssd_pkg::cand_tag_t            in_tag,
  output logic                            snap_valid,
  input  logic                            snap_ready,
  output logic [$clog2(PATCH_SIZE*PATCH_SIZE*255+1)-1:0]   snap_isum,
  output logic [$clog2(PATCH_SIZE*PATCH_SIZE*65025+1)-1:0] snap_isq,
  output logic [$clog2(PATCH_SIZE*PATCH_SIZE*65025+1)-1:0] snap_cross,
  output logic [$clog2(PATCH_SIZE*PATCH_SIZE*255+1)-1:0]   snap_tsum,
  output logic [$clog2(PATCH_SIZE*PATCH_SIZE*65025+1)-1:0] snap_tsq,
  output zmssd_pkg::cand_tag_t            snap_tag
);

  localparam int unsigned NPIX  = PATCH_SIZE * PATCH_SIZE;
  localparam int unsigned PW    = $clog2(NPIX);
  localparam int unsigned SUM_W = $clog2(NPIX * 255 + 1);
  localparam int unsigned SQ_W  = $clog2(NPIX * 65025 + 1);
  localparam int unsigned PROD_W = 2 * zmssd_pkg::PIX_W;

  logic [zmssd_pkg::PIX_W-1:0] tpl_mem [NPIX];

  logic [PW-1:0]               pcount_r, pcount_nxt;
  logic                        last_pos;
  logic                        in_fire;

  logic                        a_v_r;
  logic [zmssd_pkg::ACT_W-1:0] a_act_r;
  logic [zmssd_pkg::PIX_W-1:0] a_pix_r;
  logic [zmssd_pkg::PIX_W-1:0] a_tpl_r;
  logic [PW-1:0]               a_pos_r;
  zmssd_pkg::cand_tag_t        a_tag_r;
  logic                        a_fire;
  logic                        a_first;
  logic                        a_finish;
  logic                        a_off;

  logic [PROD_W-1:0]           pix_sq;
  logic [PROD_W-1:0]           pix_cross;

  logic [SUM_W-1:0] tsum_r, tsum_nxt, isum_r, isum_nxt;
  logic [SQ_W-1:0]  tsq_r, tsq_nxt, isq_r, isq_nxt, cross_r, cross_nxt;

  logic                        b_v_r;
  logic                        b_free;
  logic [SUM_W-1:0]            b_isum_r, b_tsum_r;
  logic [SQ_W-1:0]             b_isq_r, b_cross_r, b_tsq_r;
  zmssd_pkg::cand_tag_t        b_tag_r;

  assign b_free   = !b_v_r || snap_ready;
  assign a_fire   = a_v_r && b_free;
  assign in_ready = !a_v_r || b_free;
  assign in_fire  = in_valid && in_ready;

  assign last_pos = (pcount_r == PW'(NPIX - 1));

  always_comb begin
    case (zmssd_pkg::action_t'(in_action))
      zmssd_pkg::ACT_TEMPLATE,
      zmssd_pkg::ACT_CAND:      pcount_nxt = last_pos ? '0 : pcount_r + 1'b1;
      zmssd_pkg::ACT_OFF_IMAGE: pcount_nxt = '0;
      default:                  pcount_nxt = pcount_r;
    endcase
  end

  // Template store: written on accept, read at the same position into the input stage
  always_ff @(posedge clk) begin
    if (in_fire && (zmssd_pkg::action_t'(in_action) == zmssd_pkg::ACT_TEMPLATE)) begin
      tpl_mem[pcount_r] <= in_pixel;
    end
    if (in_fire) begin
      a_tpl_r <= tpl_mem[pcount_r];
    end
  end

  assign a_first   = (a_pos_r == '0);
  assign pix_sq    = PROD_W'(a_pix_r) * PROD_W'(a_pix_r);
  assign pix_cross = PROD_W'(a_pix_r) * PROD_W'(a_tpl_r);

  always_comb begin
    tsum_nxt  = tsum_r;
    tsq_nxt   = tsq_r;
    isum_nxt  = isum_r;
    isq_nxt   = isq_r;
    cross_nxt = cross_r;
    a_finish  = 1'b0;
    a_off     = 1'b0;
    case (zmssd_pkg::action_t'(a_act_r))
      zmssd_pkg::ACT_TEMPLATE: begin
        tsum_nxt = (a_first ? '0 : tsum_r) + SUM_W'(a_pix_r);
        tsq_nxt  = (a_first ? '0 : tsq_r) + SQ_W'(pix_sq);
      end
      zmssd_pkg::ACT_CAND: begin
        isum_nxt  = (a_first ? '0 : isum_r) + SUM_W'(a_pix_r);
        isq_nxt   = (a_first ? '0 : isq_r) + SQ_W'(pix_sq);
        cross_nxt = (a_first ? '0 : cross_r) + SQ_W'(pix_cross);
        a_finish  = (a_pos_r == PW'(NPIX - 1));
      end
      zmssd_pkg::ACT_OFF_IMAGE: begin
        isum_nxt  = '0;
        isq_nxt   = '0;
        cross_nxt = '0;
        a_finish  = 1'b1;
        a_off     = 1'b1;
      end
      default: begin
        a_finish = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r <= '0;
      a_v_r    <= 1'b0;
      b_v_r    <= 1'b0;
      tsum_r   <= '0;
      tsq_r    <= '0;
      isum_r   <= '0;
      isq_r    <= '0;
      cross_r  <= '0;
    end else begin
      if (in_fire) begin
        pcount_r <= pcount_nxt;
      end
      if (in_ready) begin
        a_v_r <= in_valid;
      end
      if (a_fire) begin
        tsum_r  <= tsum_nxt;
        tsq_r   <= tsq_nxt;
        isum_r  <= isum_nxt;
        isq_r   <= isq_nxt;
        cross_r <= cross_nxt;
      end
      if (b_free) begin
        b_v_r <= a_fire && a_finish;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      a_act_r <= in_action;
      a_pix_r <= in_pixel;
      a_pos_r <= pcount_r;
      a_tag_r <= in_tag;
    end
    if (a_fire && a_finish) begin
      b_isum_r  <= isum_nxt;
      b_isq_r   <= isq_nxt;
      b_cross_r <= cross_nxt;
      b_tsum_r  <= tsum_nxt;
      b_tsq_r   <= tsq_nxt;
      b_tag_r   <= '{cand_x:    a_tag_r.cand_x,
                     cand_y:    a_tag_r.cand_y,
                     last_cand: a_tag_r.last_cand,
                     off_image: a_off};
    end
  end

  assign snap_valid = b_v_r;
  assign snap_isum  = b_isum_r;
  assign snap_isq   = b_isq_r;
  assign snap_cross = b_cross_r;
  assign snap_tsum  = b_tsum_r;
  assign snap_tsq   = b_tsq_r;
  assign snap_tag   = b_tag_r;

endmodule

FILE: rtl/core/zmssd_score.sv
// Three-stage score pipeline: energy and squared mean difference, division of
// that square by the pixel count, subtract and clamp. Depends on zmssd_pkg.
module zmssd_score #(
  parameter int unsigned PATCH_SIZE = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            snap_valid,
  output logic                            snap_ready,
  input  logic [$clog2(PATCH_SIZE*PATCH_SIZE*255+1)-1:0]   snap_isum,
  input  logic [$clog2(PATCH_SIZE*PATCH_SIZE*65025+1)-1:0] snap_isq,
  input  logic [$clog2(PATCH_SIZE*PATCH_SIZE*65025+1)-1:0] snap_cross,
  input  logic [$clog2(PATCH_SIZE*PATCH_SIZE*255+1)-1:0]   snap_tsum,
  input  logic [$clog2(PATCH_SIZE*PATCH_SIZE*65025+1)-1:0] snap_tsq,
  input  zmssd_pkg::cand_tag_t            snap_tag,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic [zmssd_pkg::SCORE_W-1:0]   res_score,
  output zmssd_pkg::cand_tag_t            res_tag
);

  localparam int unsigned NPIX  = PATCH_SIZE * PATCH_SIZE;
  localparam int unsigned SUM_W = $clog2(NPIX * 255 + 1);
  localparam int unsigned SQ_W  = $clog2(NPIX * 65025 + 1);
  localparam int unsigned TW    = SQ_W + 2;
  localparam int unsigned XW    = 2 * SUM_W;
  localparam int unsigned LG    = $clog2(NPIX);
  localparam int unsigned SHIFT = XW + LG;
  localparam int unsigned MW    = XW + 1;
  localparam int unsigned PRW   = XW + MW;
  localparam int unsigned QW    = PRW - SHIFT;
  localparam int unsigned SW0   = (TW > QW + 1) ? TW : QW + 1;
  localparam int unsigned SW1   = (SW0 > zmssd_pkg::SCORE_W + 1) ? SW0 : zmssd_pkg::SCORE_W + 1;
  localparam int unsigned SW    = SW1 + 1;
  // ceil(2^SHIFT / NPIX): exact floor division for any dividend below 2^XW
  localparam logic [63:0] RECIP_W = ((64'd1 << SHIFT) + 64'(NPIX) - 64'd1) / 64'(NPIX);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_W);

  logic                  c_rdy, d_rdy, e_rdy;

  logic signed [TW-1:0]  t_nxt;
  logic signed [SUM_W:0] diff;
  logic [SUM_W-1:0]      diff_abs;
  logic [XW-1:0]         diff_sq;

  logic                  c_v_r;
  logic signed [TW-1:0]  c_t_r;
  logic [XW-1:0]         c_d2_r;
  zmssd_pkg::cand_tag_t  c_tag_r;

  logic [PRW-1:0]        prod;
  logic                  d_v_r;
  logic signed [TW-1:0]  d_t_r;
  logic [QW-1:0]         d_q_r;
  zmssd_pkg::cand_tag_t  d_tag_r;

  logic signed [SW-1:0]  s_full;
  logic [zmssd_pkg::SCORE_W-1:0] s_clamped;
  logic                  e_v_r;
  logic [zmssd_pkg::SCORE_W-1:0] e_score_r;
  zmssd_pkg::cand_tag_t  e_tag_r;

  assign e_rdy      = !e_v_r || res_ready;
  assign d_rdy      = !d_v_r || e_rdy;
  assign c_rdy      = !c_v_r || d_rdy;
  assign snap_ready = c_rdy;

  assign t_nxt = $signed(TW'(snap_isq)) + $signed(TW'(snap_tsq))
               - $signed(TW'({snap_cross, 1'b0}));
  assign diff     = $signed({1'b0, snap_tsum}) - $signed({1'b0, snap_isum});
  assign diff_abs = diff[SUM_W] ? SUM_W'(-diff) : diff[SUM_W-1:0];
  assign diff_sq  = XW'(diff_abs) * XW'(diff_abs);

  assign prod = PRW'(c_d2_r) * PRW'(RECIP);

  assign s_full = $signed(SW'(d_t_r)) - $signed(SW'(d_q_r));

  always_comb begin
    if (s_full < 0) begin
      s_clamped = '0;
    end else if (s_full > $signed(SW'(zmssd_pkg::SCORE_MAX))) begin
      s_clamped = zmssd_pkg::SCORE_MAX;
    end else begin
      s_clamped = s_full[zmssd_pkg::SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
    end else begin
      if (c_rdy) begin
        c_v_r <= snap_valid;
      end
      if (d_rdy) begin
        d_v_r <= c_v_r;
      end
      if (e_rdy) begin
        e_v_r <= d_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_rdy) begin
      c_t_r   <= t_nxt;
      c_d2_r  <= diff_sq;
      c_tag_r <= snap_tag;
    end
    if (d_rdy) begin
      d_t_r   <= c_t_r;
      d_q_r   <= prod[PRW-1:SHIFT];
      d_tag_r <= c_tag_r;
    end
    if (e_rdy) begin
      e_score_r <= s_clamped;
      e_tag_r   <= d_tag_r;
    end
  end

  assign res_valid = e_v_r;
  assign res_score = e_score_r;
  assign res_tag   = e_tag_r;

endmodule

FILE: rtl/core/zmssd_best.sv
// Search tracker: max_score register, running best score and position, and the
// result output register. Depends on zmssd_pkg.
module zmssd_best (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [zmssd_pkg::SCORE_W-1:0]   cfg_wr_data,
  input  logic                            res_valid,
  output logic                            res_ready,
  input  logic [zmssd_pkg::SCORE_W-1:0]   res_score,
  input  zmssd_pkg::cand_tag_t            res_tag,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [zmssd_pkg::SCORE_W-1:0]   out_score,
  output logic                            out_search_done,
  output logic                            out_found,
  output logic [zmssd_pkg::COORD_W-1:0]   out_best_x,
  output logic [zmssd_pkg::COORD_W-1:0]   out_best_y
);

  function automatic logic [zmssd_pkg::SCORE_W-1:0] over_limit(
    input logic [zmssd_pkg::SCORE_W-1:0] limit
  );
    return (limit == zmssd_pkg::SCORE_MAX) ? zmssd_pkg::SCORE_MAX : limit + 1'b1;
  endfunction

  logic [zmssd_pkg::SCORE_W-1:0] max_r;
  logic [zmssd_pkg::SCORE_W-1:0] best_r, best_nxt;
  logic [zmssd_pkg::COORD_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [zmssd_pkg::SCORE_W-1:0] score_f;
  logic                          res_fire;
  logic                          found;

  logic                          out_v_r;
  logic [zmssd_pkg::SCORE_W-1:0] out_score_r;
  logic                          out_done_r;
  logic                          out_found_r;
  logic [zmssd_pkg::COORD_W-1:0] out_bx_r, out_by_r;

  assign res_ready = !out_v_r || out_ready;
  assign res_fire  = res_valid && res_ready;

  assign score_f = res_tag.off_image ? over_limit(max_r) : res_score;

  // Ties keep the earlier candidate
  always_comb begin
    if (score_f < best_r) begin
      best_nxt = score_f;
      col_nxt  = res_tag.cand_x;
      row_nxt  = res_tag.cand_y;
    end else begin
      best_nxt = best_r;
      col_nxt  = col_r;
      row_nxt  = row_r;
    end
  end

  assign found = (best_nxt < max_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      max_r   <= zmssd_pkg::MAX_SCORE_RST;
      best_r  <= over_limit(zmssd_pkg::MAX_SCORE_RST);
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      if (res_ready) begin
        out_v_r <= res_valid;
      end
      if (cfg_wr_en) begin
        max_r  <= cfg_wr_data;
        best_r <= over_limit(cfg_wr_data);
        col_r  <= '0;
        row_r  <= '0;
      end else if (res_fire) begin
        // restart the search after its closing item
        if (res_tag.last_cand) begin
          best_r <= over_limit(max_r);
          col_r  <= '0;
          row_r  <= '0;
        end else begin
          best_r <= best_nxt;
          col_r  <= col_nxt;
          row_r  <= row_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_score_r <= score_f;
      out_done_r  <= res_tag.last_cand;
      out_found_r <= res_tag.last_cand && found;
      out_bx_r    <= (res_tag.last_cand && found) ? col_nxt : '0;
      out_by_r    <= (res_tag.last_cand && found) ? row_nxt : '0;
    end
  end

  assign out_valid       = out_v_r;
  assign out_score       = out_score_r;
  assign out_search_done = out_done_r;
  assign out_found       = out_found_r;
  assign out_best_x      = out_bx_r;
  assign out_best_y      = out_by_r;

endmodule
